// File: sv/lrub_pkg.sv
// Package for the LRU byte-budget cache policy block.
// Holds sizes, operation and result codes and the controller state type.
// No dependencies.
`default_nettype none
package lrub_pkg;
	localparam int ENTRIES = 32;
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int BYTES_W = 24;
	localparam int TOT_W = BYTES_W + $clog2(ENTRIES);
	localparam int KEY_W = 32;
	localparam int STAMP_W = 32;
	localparam logic [BYTES_W-1:0] BUDGET_RESET = 24'd8388608;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_TOUCH  = 2'd1,
		OP_FREE   = 2'd2,
		OP_RESIZE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_EVICT    = 2'd0,
		KIND_DONE     = 2'd1,
		KIND_NOTFOUND = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		SM_FIND,
		SM_EVICT,
		SM_RENUM
	} scan_mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCANNED,
		ST_FIT,
		ST_EVICT,
		ST_PLACE,
		ST_STAMP,
		ST_NOTFOUND,
		ST_DONE
	} state_t;
endpackage
`default_nettype wire

// File: sv/lrub_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for every table store of the cache policy block.
`default_nettype none
module lrub_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: sv/lru_sized_block_cache_policy.sv
// Top level of the LRU byte-budget cache policy block: controller, scan unit, valid bits.
// Depends on lrub_pkg and lrub_ram (key, size and stamp stores).
//
//  channel | signals                              | direction
//  in      | in_valid in_ready op block_addr ...   | request in
//  out     | out_valid out_ready kind out_addr ... | results out
//  cfg     | cfg_valid cfg_ready cfg_data          | budget write in
//
// Every table search is a sequential pass over the stores, one slot read per cycle.
// An insert with room needs no search pass. Each eviction takes one pass and each release
// round ends in a fit check; a round that runs out of entries adds one pass, and a stamp
// wrap one pass per valid entry plus one.
// Reset clears the valid bits, the byte total and the stamp counter at once; no clearing pass.
// A result waiting in the output register stalls the controller only when another is due.
`default_nettype none
module lru_sized_block_cache_policy (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    op,
	input  wire logic [lrub_pkg::KEY_W-1:0]    block_addr,
	input  wire logic [lrub_pkg::BYTES_W-1:0]  block_bytes,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [1:0]                         kind,
	output logic [lrub_pkg::KEY_W-1:0]         out_addr,
	output logic [lrub_pkg::BYTES_W-1:0]       used_bytes,
	output logic                               last,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [lrub_pkg::BYTES_W-1:0]  cfg_data
);
	import lrub_pkg::*;

	state_t state_q, state_d;
	scan_mode_t mode_q;
	op_t op_q;
	logic [KEY_W-1:0] addr_q;
	logic [BYTES_W-1:0] bytes_q, budget_q;
	logic [ENTRIES-1:0] valid_q, done_q;
	logic [TOT_W-1:0] total_q;
	logic [STAMP_W-1:0] counter_q;
	logic [CNT_W-1:0] rank_q, cnt_q;
	logic resized_q, in_round_q;
	logic [IDX_W-1:0] slot_q;
	logic [BYTES_W-1:0] slot_size_q;
	logic [BYTES_W:0] to_free_q;

	// scan pipeline and best candidate
	logic rd_v_s1;
	logic [IDX_W-1:0] idx_s1;
	logic found_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [STAMP_W-1:0] best_stamp_q;
	logic [KEY_W-1:0] best_key_q;
	logic [BYTES_W-1:0] best_size_q;

	logic [KEY_W-1:0] key_rd;
	logic [BYTES_W-1:0] size_rd;
	logic [STAMP_W-1:0] stamp_rd;

	logic key_we, size_we, stamp_we;
	logic [IDX_W-1:0] key_wa, size_wa, stamp_wa;
	logic [BYTES_W-1:0] size_wd;
	logic [STAMP_W-1:0] stamp_wd;

	logic can_emit, emit_en, scan_last, start_scan;
	kind_t emit_kind;
	logic [KEY_W-1:0] emit_addr;
	logic [TOT_W-1:0] emit_total;
	logic emit_last;

	logic fits, full, free_found, wrap;
	logic [IDX_W-1:0] free_idx;
	logic [TOT_W-1:0] base, tot_evict;
	logic [TOT_W:0] need;
	logic [BYTES_W:0] tf_cur, tf_new;
	logic elig, take;

	lrub_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key (
		.clk(clk), .we(key_we), .waddr(key_wa), .wdata(addr_q),
		.raddr(cnt_q[IDX_W-1:0]), .rdata(key_rd)
	);
	lrub_ram #(.WIDTH(BYTES_W), .DEPTH(ENTRIES)) u_size (
		.clk(clk), .we(size_we), .waddr(size_wa), .wdata(size_wd),
		.raddr(cnt_q[IDX_W-1:0]), .rdata(size_rd)
	);
	lrub_ram #(.WIDTH(STAMP_W), .DEPTH(ENTRIES)) u_stamp (
		.clk(clk), .we(stamp_we), .waddr(stamp_wa), .wdata(stamp_wd),
		.raddr(cnt_q[IDX_W-1:0]), .rdata(stamp_rd)
	);

	assign cfg_ready = 1'b1;
	assign can_emit = !out_valid || out_ready;
	assign scan_last = rd_v_s1 && (idx_s1 == IDX_W'(ENTRIES - 1));
	assign full = &valid_q;
	assign wrap = &counter_q;

	always_comb begin
		free_found = 1'b0;
		free_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		base = resized_q ? (total_q - TOT_W'(slot_size_q)) : total_q;
		need = {1'b0, base} + (TOT_W+1)'(bytes_q);
		fits = (need <= (TOT_W+1)'(budget_q)) && !(op_q == OP_INSERT && full);
		tot_evict = total_q - TOT_W'(best_size_q);
		tf_cur = in_round_q ? to_free_q : {bytes_q, 1'b0};
		tf_new = ((BYTES_W+1)'(best_size_q) >= tf_cur) ? '0
			: tf_cur - (BYTES_W+1)'(best_size_q);
	end

	// Candidate test on the entry that the store has just returned.
	always_comb begin
		elig = valid_q[idx_s1] && !done_q[idx_s1] && !(resized_q && idx_s1 == slot_q);
		if (mode_q == SM_FIND) begin
			take = elig && !found_q && key_rd == addr_q;
		end else begin
			take = elig && (!found_q || stamp_rd < best_stamp_q);
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (op_t'(op) == OP_INSERT) ? ST_FIT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_SCANNED;
				end
			end
			ST_SCANNED: begin
				unique case (mode_q)
					SM_FIND: begin
						if (!found_q) begin
							state_d = ST_NOTFOUND;
						end else begin
							unique case (op_q)
								OP_TOUCH: state_d = ST_STAMP;
								OP_FREE: state_d = ST_DONE;
								default: state_d = ST_FIT;
							endcase
						end
					end
					SM_EVICT: state_d = found_q ? ST_EVICT : ST_PLACE;
					default: state_d = found_q ? ST_SCAN : ST_DONE;
				endcase
			end
			ST_FIT: state_d = fits ? ST_PLACE : ST_SCAN;
			ST_EVICT: begin
				if (can_emit) begin
					state_d = (tf_new != '0) ? ST_SCAN : ST_FIT;
				end
			end
			ST_PLACE: begin
				state_d = (op_q == OP_INSERT && free_found && wrap) ? ST_SCAN : ST_DONE;
			end
			ST_STAMP: state_d = wrap ? ST_SCAN : ST_DONE;
			ST_NOTFOUND, ST_DONE: begin
				if (can_emit) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		in_ready = 1'b0;
		emit_en = 1'b0;
		emit_kind = KIND_DONE;
		emit_addr = addr_q;
		emit_total = total_q;
		emit_last = 1'b1;
		start_scan = 1'b0;
		key_we = 1'b0;
		key_wa = free_idx;
		size_we = 1'b0;
		size_wa = free_idx;
		size_wd = bytes_q;
		stamp_we = 1'b0;
		stamp_wa = free_idx;
		stamp_wd = counter_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				start_scan = in_valid && op_t'(op) != OP_INSERT;
			end
			ST_SCANNED: begin
				if (mode_q == SM_RENUM && found_q) begin
					stamp_we = 1'b1;
					stamp_wa = best_idx_q;
					stamp_wd = STAMP_W'(rank_q);
					start_scan = 1'b1;
				end
			end
			ST_FIT: start_scan = !fits;
			ST_EVICT: begin
				emit_en = can_emit;
				emit_kind = KIND_EVICT;
				emit_addr = best_key_q;
				emit_total = tot_evict;
				emit_last = 1'b0;
				start_scan = can_emit && tf_new != '0;
			end
			ST_PLACE: begin
				if (op_q == OP_INSERT) begin
					key_we = free_found;
					size_we = free_found;
					stamp_we = free_found;
					start_scan = free_found && wrap;
				end else begin
					size_we = 1'b1;
					size_wa = slot_q;
				end
			end
			ST_STAMP: begin
				stamp_we = 1'b1;
				stamp_wa = slot_q;
				start_scan = wrap;
			end
			ST_NOTFOUND: begin
				emit_en = can_emit;
				emit_kind = KIND_NOTFOUND;
			end
			ST_DONE: emit_en = can_emit;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			done_q <= '0;
			total_q <= '0;
			counter_q <= '0;
			budget_q <= BUDGET_RESET;
			resized_q <= 1'b0;
			in_round_q <= 1'b0;
			slot_q <= '0;
			slot_size_q <= '0;
			to_free_q <= '0;
			rd_v_s1 <= 1'b0;
			cnt_q <= '0;
			found_q <= 1'b0;
			rank_q <= '0;
			mode_q <= SM_FIND;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				budget_q <= cfg_data;
			end

			// scan pipeline
			rd_v_s1 <= (state_q == ST_SCAN) && cnt_q < CNT_W'(ENTRIES);
			if (state_q == ST_SCAN && cnt_q < CNT_W'(ENTRIES)) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (rd_v_s1 && take) begin
				found_q <= 1'b1;
			end
			if (start_scan) begin
				cnt_q <= '0;
				found_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						resized_q <= 1'b0;
						in_round_q <= 1'b0;
						done_q <= '0;
						mode_q <= SM_FIND;
					end
				end
				ST_SCANNED: begin
					if (mode_q == SM_FIND && found_q) begin
						slot_q <= best_idx_q;
						slot_size_q <= best_size_q;
						if (op_q == OP_FREE) begin
							valid_q[best_idx_q] <= 1'b0;
							total_q <= total_q - TOT_W'(best_size_q);
						end
						if (op_q == OP_RESIZE) begin
							resized_q <= 1'b1;
						end
					end
					if (mode_q == SM_RENUM) begin
						if (found_q) begin
							done_q[best_idx_q] <= 1'b1;
							rank_q <= rank_q + 1'b1;
						end else begin
							counter_q <= STAMP_W'(rank_q);
						end
					end
				end
				ST_FIT: begin
					if (!fits) begin
						mode_q <= SM_EVICT;
					end
				end
				ST_EVICT: begin
					if (can_emit) begin
						valid_q[best_idx_q] <= 1'b0;
						total_q <= tot_evict;
						to_free_q <= tf_new;
						in_round_q <= tf_new != '0;
					end
				end
				ST_PLACE: begin
					if (op_q == OP_INSERT) begin
						if (free_found) begin
							valid_q[free_idx] <= 1'b1;
							total_q <= total_q + TOT_W'(bytes_q);
							counter_q <= counter_q + 1'b1;
							if (wrap) begin
								mode_q <= SM_RENUM;
								rank_q <= '0;
								done_q <= '0;
							end
						end
					end else begin
						total_q <= total_q - TOT_W'(slot_size_q) + TOT_W'(bytes_q);
					end
				end
				ST_STAMP: begin
					counter_q <= counter_q + 1'b1;
					if (wrap) begin
						mode_q <= SM_RENUM;
						rank_q <= '0;
						done_q <= '0;
					end
				end
				default: ;
			endcase

			if (emit_en) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			op_q <= op_t'(op);
			addr_q <= block_addr;
			bytes_q <= block_bytes;
		end
		idx_s1 <= cnt_q[IDX_W-1:0];
		if (rd_v_s1 && take) begin
			best_idx_q <= idx_s1;
			best_stamp_q <= stamp_rd;
			best_key_q <= key_rd;
			best_size_q <= size_rd;
		end
		if (emit_en) begin
			kind <= emit_kind;
			out_addr <= emit_addr;
			used_bytes <= emit_total[BYTES_W-1:0];
			last <= emit_last;
		end
	end

`ifndef SYNTHESIS
	// While idle, any result still waiting must be the closing one of its request.
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ready && out_valid) |-> last)
		else $error("idle with a non-final result pending");
	a_evict_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_EVICT) |-> !in_ready)
		else $error("eviction result while idle");
	a_scan_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (cnt_q <= CNT_W'(ENTRIES)))
		else $error("scan counter out of range");
	a_rank: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == SM_RENUM && state_q == ST_SCANNED && found_q)
		|-> (rank_q < CNT_W'(ENTRIES)))
		else $error("renumber rank overrun");
	a_evict_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVICT) |-> (found_q && valid_q[best_idx_q]))
		else $error("evicting an entry that is not held");
`endif
endmodule
`default_nettype wire
